@@ rtl/core/rotation_matrix_to_quaternion_unit_defines.svh @@
// assertion macros for the rotation matrix to quaternion unit
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

@@ rtl/core/rmq_pkg.sv @@
// shared types and helpers for the rotation matrix to quaternion unit
`default_nettype none

package rmq_pkg;

    // pivot axis; AXIS_W marks the positive trace branch
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_W = 2'd3
    } axis_t;

    typedef struct packed {
        logic  bad;
        axis_t axis;
    } rmq_ctl_t;

    // cyclic successor x -> y -> z -> x
    function automatic axis_t next_axis(input axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rotation_matrix_to_quaternion_unit.sv @@
// top level: rotation matrix to quaternion, fully pipelined
//
// channel   dir  payload                                   handshake
// s_axis    in   tdata: m00..m22 (9 x DATA_WIDTH)          tvalid/tready
// m_axis    out  tdata: qx,qy,qz,qw; tuser: invalid        tvalid/tready
//
// one word per cycle in and out while the pipeline advances; a word passes
// the setup register, R root stages, Q divider stages and the output
// register; R = (DATA_WIDTH+FRAC_BITS+3)/2 and Q = DATA_WIDTH+1+FRAC_BITS
// the whole pipeline advances together; it halts only while the output
// register holds a word that m_axis_tready does not take
// rst_n clears every valid bit asynchronously; payload registers are not reset
`default_nettype none

module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS  = 14,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // qx, qy, qz, qw from bit 0 up
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // invalid
    output logic [0:0]                                m_axis_tuser
);
    import rmq_pkg::*;

    `include "rotation_matrix_to_quaternion_unit_defines.svh"

    localparam int DW   = DATA_WIDTH;
    localparam int MW   = DW + 1;
    localparam int XW   = MW + FRAC_BITS;
    localparam int RW   = (DW + FRAC_BITS + 3) / 2;
    localparam int OTW  = ((4*DW+7)/8)*8;
    localparam int CW   = $bits(rmq_ctl_t);
    localparam int SB1  = CW + 3 + 3*MW;
    localparam int SB2  = CW + 3 + RW;

    localparam logic [XW-1:0] MAXP = {{(FRAC_BITS+2){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [XW-1:0] MINM = MAXP + XW'(1);

    // pipeline advance: output register empty or being drained
    logic ce;

    // setup stage
    logic                  su_valid;
    rmq_ctl_t              su_ctl;
    logic [DW+FRAC_BITS+1:0] su_rad;
    logic [2:0]            su_neg;
    logic [3*MW-1:0]       su_mag;

    // root stages
    logic                  sq_valid;
    logic [RW-1:0]         sq_root;
    logic [SB1-1:0]        sq_sb;
    rmq_ctl_t              sq_ctl;
    logic [2:0]            sq_neg;
    logic [3*MW-1:0]       sq_mag;

    // divider stages
    logic                  dv_valid;
    logic [3*XW-1:0]       dv_quo;
    logic [SB2-1:0]        dv_sb;
    rmq_ctl_t              dv_ctl;
    logic [2:0]            dv_neg;
    logic [RW-1:0]         dv_root;

    // output stage
    logic signed [DW-1:0]  lane [3];
    logic signed [DW-1:0]  half;
    logic [4*DW-1:0]       data_next;
    logic                  out_valid_reg;
    logic [4*DW-1:0]       data_reg;
    logic                  inv_reg;

    assign ce            = m_axis_tready || !out_valid_reg;
    assign s_axis_tready = ce;

    rmq_setup #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .mat       (s_axis_tdata[9*DW-1:0]),
        .out_valid (su_valid),
        .ctl       (su_ctl),
        .radicand  (su_rad),
        .neg       (su_neg),
        .mag       (su_mag)
    );

    rmq_sqrt #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS),
        .SB_WIDTH   (SB1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (su_valid),
        .radicand  (su_rad),
        .in_sb     ({su_ctl, su_neg, su_mag}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_sb    (sq_sb)
    );

    assign {sq_ctl, sq_neg, sq_mag} = sq_sb;

    rmq_div #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS),
        .SB_WIDTH   (SB2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .mag       (sq_mag),
        .in_sb     ({sq_ctl, sq_neg, sq_root}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_sb    (dv_sb)
    );

    assign {dv_ctl, dv_neg, dv_root} = dv_sb;

    // sign and saturate the three quotients, saturate the half root
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (!dv_neg[l])
            begin
                lane[l] = (dv_quo[l*XW +: XW] > MAXP) ? MAXP[DW-1:0]
                                                      : dv_quo[l*XW +: DW];
            end
            else
            begin
                lane[l] = (dv_quo[l*XW +: XW] > MINM) ? MINM[DW-1:0]
                                                      : DW'(-dv_quo[l*XW +: DW]);
            end
        end
        half = (XW'(dv_root[RW-1:1]) > MAXP) ? MAXP[DW-1:0] : DW'(dv_root[RW-1:1]);

        // qw is the top field, qx the bottom
        case (dv_ctl.axis)
            AXIS_X:  data_next = {lane[0], lane[2], lane[1], half};
            AXIS_Y:  data_next = {lane[0], lane[1], half, lane[2]};
            AXIS_Z:  data_next = {lane[0], half, lane[2], lane[1]};
            default: data_next = {half, lane[2], lane[1], lane[0]};
        endcase
        if (dv_ctl.bad)
        begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce && dv_valid)
        begin
            data_reg <= data_next;
            inv_reg  <= dv_ctl.bad;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OTW'(data_reg);
    assign m_axis_tuser  = inv_reg;

    // a flagged word carries all-zero components
    `RMQ_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
    // an accepted word reaches the setup register on the next edge
    `RMQ_ASSERT_NEXT(a_enter_setup, s_axis_tvalid && s_axis_tready, su_valid)
    // a held output freezes the setup stage
    `RMQ_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, $stable(su_valid))

endmodule

`default_nettype wire

@@ rtl/core/rmq_setup.sv @@
// first stage: trace, pivot choice, root argument and numerator magnitudes
`default_nettype none

module rmq_setup #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 ce,
    input  wire logic                                 in_valid,
    input  wire logic [9*DATA_WIDTH-1:0]              mat,
    output logic                                      out_valid,
    output rmq_pkg::rmq_ctl_t                         ctl,
    output logic [DATA_WIDTH+FRAC_BITS+1:0]           radicand,
    output logic [2:0]                                neg,
    output logic [3*(DATA_WIDTH+1)-1:0]               mag
);
    import rmq_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int AW = DW + 3;
    localparam logic signed [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [DW-1:0] e [3][3];
    logic signed [AW-1:0] trace, arg, dii, djj, dkk;
    logic signed [DW:0]   num [3];
    axis_t                ai, aj, ak;
    rmq_ctl_t             ctl_next;
    logic [DW+FRAC_BITS+1:0] rad_next;
    logic [2:0]           neg_next;
    logic [3*(DW+1)-1:0]  mag_next;

    logic                 valid_reg;
    rmq_ctl_t             ctl_reg;
    logic [DW+FRAC_BITS+1:0] rad_reg;
    logic [2:0]           neg_reg;
    logic [3*(DW+1)-1:0]  mag_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e[r][c] = mat[(3*r+c)*DW +: DW];
            end
        end
    end

    always_comb
    begin
        trace = AW'(e[0][0]) + AW'(e[1][1]) + AW'(e[2][2]);
        ai = AXIS_X;
        if (e[1][1] > e[0][0])
        begin
            ai = AXIS_Y;
        end
        if (e[2][2] > e[ai][ai])
        begin
            ai = AXIS_Z;
        end
        aj  = next_axis(ai);
        ak  = next_axis(aj);
        dii = AW'(e[ai][ai]);
        djj = AW'(e[aj][aj]);
        dkk = AW'(e[ak][ak]);
        arg = dii - djj - dkk + ONE;

        if (trace > 0)
        begin
            ctl_next.bad  = 1'b0;
            ctl_next.axis = AXIS_W;
            rad_next = {trace[DW+1:0] + ONE[DW+1:0], {FRAC_BITS{1'b0}}};
            num[0] = (DW+1)'(e[2][1]) - (DW+1)'(e[1][2]);
            num[1] = (DW+1)'(e[0][2]) - (DW+1)'(e[2][0]);
            num[2] = (DW+1)'(e[1][0]) - (DW+1)'(e[0][1]);
        end
        else
        begin
            ctl_next.bad  = (arg <= 0);
            ctl_next.axis = ai;
            rad_next = {arg[DW+1:0], {FRAC_BITS{1'b0}}};
            num[0] = (DW+1)'(e[ak][aj]) - (DW+1)'(e[aj][ak]);
            num[1] = (DW+1)'(e[aj][ai]) + (DW+1)'(e[ai][aj]);
            num[2] = (DW+1)'(e[ak][ai]) + (DW+1)'(e[ai][ak]);
        end

        for (int l = 0; l < 3; l++)
        begin
            neg_next[l] = num[l][DW];
            mag_next[l*(DW+1) +: DW+1] = num[l][DW] ? (DW+1)'(-num[l]) : (DW+1)'(num[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce && in_valid)
        begin
            ctl_reg <= ctl_next;
            rad_reg <= rad_next;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctl       = ctl_reg;
    assign radicand  = rad_reg;
    assign neg       = neg_reg;
    assign mag       = mag_reg;

endmodule

`default_nettype wire

@@ rtl/core/rmq_sqrt.sv @@
// pipelined integer square root, one root bit per stage
`default_nettype none

module rmq_sqrt #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int SB_WIDTH   = 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               ce,
    input  wire logic                               in_valid,
    input  wire logic [DATA_WIDTH+FRAC_BITS+1:0]    radicand,
    input  wire logic [SB_WIDTH-1:0]                in_sb,
    output logic                                    out_valid,
    output logic [(DATA_WIDTH+FRAC_BITS+3)/2-1:0]   root,
    output logic [SB_WIDTH-1:0]                     out_sb
);
    localparam int SW = DATA_WIDTH + FRAC_BITS + 2;
    localparam int RW = (SW + 1) / 2;
    localparam int PW = 2 * RW;

    logic              v_reg    [RW];
    logic [RW+2:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [PW-1:0]     rad_reg  [RW];
    logic [SB_WIDTH-1:0] sb_reg [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic              v_in;
        logic [RW+2:0]     rem_in, rem_sh, trial, rem_next;
        logic [RW-1:0]     root_in, root_next;
        logic [PW-1:0]     rad_in;
        logic [SB_WIDTH-1:0] sb_in;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = PW'(radicand);
            assign sb_in   = in_sb;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
            assign sb_in   = sb_reg[s-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[RW:0], rad_in[PW-1:PW-2]};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce && v_in)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= {rad_in[PW-3:0], 2'b00};
                sb_reg[s]   <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_sb    = sb_reg[RW-1];

endmodule

`default_nettype wire

@@ rtl/core/rmq_div.sv @@
// three-lane pipelined restoring divider, one quotient bit per stage
`default_nettype none

module rmq_div #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int SB_WIDTH   = 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 ce,
    input  wire logic                                 in_valid,
    input  wire logic [(DATA_WIDTH+FRAC_BITS+3)/2-1:0] root,
    input  wire logic [3*(DATA_WIDTH+1)-1:0]          mag,
    input  wire logic [SB_WIDTH-1:0]                  in_sb,
    output logic                                      out_valid,
    output logic [3*(DATA_WIDTH+1+FRAC_BITS)-1:0]     quo,
    output logic [SB_WIDTH-1:0]                       out_sb
);
    localparam int RW  = (DATA_WIDTH + FRAC_BITS + 3) / 2;
    localparam int DNW = RW + 1;
    localparam int MW  = DATA_WIDTH + 1;
    localparam int XW  = MW + FRAC_BITS;

    logic              v_reg   [XW];
    logic [DNW-1:0]    den_reg [XW];
    logic [SB_WIDTH-1:0] sb_reg [XW];
    logic [DNW-1:0]    rem_reg [XW][3];
    logic [XW-1:0]     x_reg   [XW][3];

    for (genvar s = 0; s < XW; s++)
    begin : g_stage
        logic              v_in;
        logic [DNW-1:0]    den_in;
        logic [SB_WIDTH-1:0] sb_in;
        logic [DNW-1:0]    rem_in  [3];
        logic [XW-1:0]     x_in    [3];
        logic [DNW:0]      r2      [3];
        logic [DNW-1:0]    rem_next[3];
        logic [XW-1:0]     x_next  [3];

        if (s == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign den_in = {root, 1'b0};
            assign sb_in  = in_sb;
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_in[l] = '0;
                assign x_in[l]   = {mag[l*MW +: MW], {FRAC_BITS{1'b0}}};
            end
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign den_in = den_reg[s-1];
            assign sb_in  = sb_reg[s-1];
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_in[l] = rem_reg[s-1][l];
                assign x_in[l]   = x_reg[s-1][l];
            end
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                r2[l] = {rem_in[l], x_in[l][XW-1]};
                if (r2[l] >= {1'b0, den_in})
                begin
                    rem_next[l] = DNW'(r2[l] - {1'b0, den_in});
                    x_next[l]   = {x_in[l][XW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = r2[l][DNW-1:0];
                    x_next[l]   = {x_in[l][XW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce && v_in)
            begin
                den_reg[s] <= den_in;
                sb_reg[s]  <= sb_in;
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[s][l] <= rem_next[l];
                    x_reg[s][l]   <= x_next[l];
                end
            end
        end
    end

    assign out_valid = v_reg[XW-1];
    assign out_sb    = sb_reg[XW-1];
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        assign quo[l*XW +: XW] = x_reg[XW-1][l];
    end

endmodule

`default_nettype wire
